FILE: sv/gpiopi_pkg.sv
// ----------------------------------------------------------------------------
// GPIO port package
// Shared constants, register word addresses and item types of the GPIO port.
// ----------------------------------------------------------------------------
package gpiopi_pkg;

	localparam int unsigned NUM_PINS = 32;
	localparam logic [31:0] PIN_MASK = 32'((64'd1 << NUM_PINS) - 64'd1);

	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	localparam logic [5:0] ADR_IVAL    = 6'd0;
	localparam logic [5:0] ADR_MODE0   = 6'd2;
	localparam logic [5:0] ADR_MODE1   = 6'd3;
	localparam logic [5:0] ADR_OVAL    = 6'd4;
	localparam logic [5:0] ADR_RISE_IE = 6'd5;
	localparam logic [5:0] ADR_RISE_IP = 6'd6;
	localparam logic [5:0] ADR_FALL_IE = 6'd7;
	localparam logic [5:0] ADR_FALL_IP = 6'd8;
	localparam logic [5:0] ADR_HIGH_IE = 6'd9;
	localparam logic [5:0] ADR_HIGH_IP = 6'd10;
	localparam logic [5:0] ADR_LOW_IE  = 6'd11;
	localparam logic [5:0] ADR_LOW_IP  = 6'd12;
	localparam logic [5:0] ADR_OMASK   = 6'd17;
	localparam logic [5:0] ADR_SET     = 6'd18;
	localparam logic [5:0] ADR_RESET   = 6'd19;
	localparam logic [5:0] ADR_TOGGLE  = 6'd20;
	localparam logic [5:0] ADR_PULL0   = 6'd21;
	localparam logic [5:0] ADR_PULL1   = 6'd22;
	localparam logic [5:0] ADR_STATUS  = 6'd36;

	typedef struct packed {
		logic [31:0] pin_levels;
		logic [31:0] write_data;
		logic [5:0]  word_address;
		logic [1:0]  operation;
	} in_item_t;

	typedef struct packed {
		logic        irq_line;
		logic [31:0] pad_pull_down;
		logic [31:0] pad_pull_up;
		logic [31:0] pad_drive_enable;
		logic [31:0] pad_out_value;
		logic [31:0] read_data;
	} res_item_t;

	localparam int unsigned IN_W      = $bits(in_item_t);
	localparam int unsigned RES_W     = $bits(res_item_t);
	localparam int unsigned OUT_W     = ((RES_W + 7) / 8) * 8;
	localparam int unsigned OUT_PAD_W = OUT_W - RES_W;

endpackage

FILE: sv/gpiopi_regs.sv
// ----------------------------------------------------------------------------
// GPIO port register file
// Holds the pin state words, performs one bus access per transaction, sets
// the pending bits and forms the result of the transaction.
// ----------------------------------------------------------------------------
module gpiopi_regs import gpiopi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	output res_item_t res
);

	logic [31:0] prev_q, oval_q, mode0_q, mode1_q, pull0_q, pull1_q;
	logic [31:0] rise_ie_q, rise_ip_q, fall_ie_q, fall_ip_q;
	logic [31:0] high_ie_q, high_ip_q, low_ie_q, low_ip_q;

	logic [31:0] prev_d, oval_d, mode0_d, mode1_d, pull0_d, pull1_d;
	logic [31:0] rise_ie_d, rise_ip_d, fall_ie_d, fall_ip_d;
	logic [31:0] high_ie_d, high_ip_d, low_ie_d, low_ip_d;

	logic [31:0] pins, data, status, rd;

	assign pins   = item.pin_levels & PIN_MASK;
	assign data   = item.write_data & PIN_MASK;
	assign status = ((rise_ip_q & rise_ie_q) | (fall_ip_q & fall_ie_q) |
			(high_ip_q & high_ie_q) | (low_ip_q & low_ie_q)) & PIN_MASK;

	always_comb begin
		rd = '0;
		if (item.operation == OP_READ) begin
			case (item.word_address)
				ADR_IVAL:    rd = pins;
				ADR_MODE0:   rd = mode0_q;
				ADR_MODE1:   rd = mode1_q;
				ADR_OVAL:    rd = oval_q;
				ADR_RISE_IE: rd = rise_ie_q;
				ADR_RISE_IP: rd = rise_ip_q;
				ADR_FALL_IE: rd = fall_ie_q;
				ADR_FALL_IP: rd = fall_ip_q;
				ADR_HIGH_IE: rd = high_ie_q;
				ADR_HIGH_IP: rd = high_ip_q;
				ADR_LOW_IE:  rd = low_ie_q;
				ADR_LOW_IP:  rd = low_ip_q;
				ADR_PULL0:   rd = pull0_q;
				ADR_PULL1:   rd = pull1_q;
				ADR_STATUS:  rd = status;
				default:     rd = '0;
			endcase
		end
	end

	always_comb begin
		oval_d    = oval_q;
		mode0_d   = mode0_q;
		mode1_d   = mode1_q;
		pull0_d   = pull0_q;
		pull1_d   = pull1_q;
		rise_ie_d = rise_ie_q;
		rise_ip_d = rise_ip_q;
		fall_ie_d = fall_ie_q;
		fall_ip_d = fall_ip_q;
		high_ie_d = high_ie_q;
		high_ip_d = high_ip_q;
		low_ie_d  = low_ie_q;
		low_ip_d  = low_ip_q;
		if (item.operation == OP_WRITE) begin
			case (item.word_address)
				ADR_MODE0:   mode0_d   = data;
				ADR_MODE1:   mode1_d   = data;
				ADR_OVAL:    oval_d    = data;
				ADR_RISE_IE: rise_ie_d = data;
				ADR_RISE_IP: rise_ip_d = rise_ip_q & data;
				ADR_FALL_IE: fall_ie_d = data;
				ADR_FALL_IP: fall_ip_d = fall_ip_q & data;
				ADR_HIGH_IE: high_ie_d = data;
				ADR_HIGH_IP: high_ip_d = high_ip_q & data;
				ADR_LOW_IE:  low_ie_d  = data;
				ADR_LOW_IP:  low_ip_d  = low_ip_q & data;
				ADR_SET:     oval_d    = oval_q | data;
				ADR_RESET:   oval_d    = oval_q & ~data;
				ADR_TOGGLE:  oval_d    = (oval_q ^ data) & PIN_MASK;
				ADR_PULL0:   pull0_d   = data;
				ADR_PULL1:   pull1_d   = data;
				default:     oval_d    = oval_q;
			endcase
		end
		// Pin events win over a clearing write in the same transaction.
		rise_ip_d = rise_ip_d | (pins & ~prev_q);
		fall_ip_d = fall_ip_d | (~pins & prev_q & PIN_MASK);
		high_ip_d = high_ip_d | pins;
		low_ip_d  = low_ip_d | (~pins & PIN_MASK);
		prev_d    = pins;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			oval_q    <= '0;
			mode0_q   <= '0;
			mode1_q   <= '0;
			pull0_q   <= '0;
			pull1_q   <= '0;
			rise_ie_q <= '0;
			rise_ip_q <= '0;
			fall_ie_q <= '0;
			fall_ip_q <= '0;
			high_ie_q <= '0;
			high_ip_q <= '0;
			low_ie_q  <= '0;
			low_ip_q  <= '0;
		end else if (step) begin
			prev_q    <= prev_d;
			oval_q    <= oval_d;
			mode0_q   <= mode0_d;
			mode1_q   <= mode1_d;
			pull0_q   <= pull0_d;
			pull1_q   <= pull1_d;
			rise_ie_q <= rise_ie_d;
			rise_ip_q <= rise_ip_d;
			fall_ie_q <= fall_ie_d;
			fall_ip_q <= fall_ip_d;
			high_ie_q <= high_ie_d;
			high_ip_q <= high_ip_d;
			low_ie_q  <= low_ie_d;
			low_ip_q  <= low_ip_d;
		end
	end

	assign res.read_data        = rd & PIN_MASK;
	assign res.pad_out_value    = oval_d;
	assign res.pad_drive_enable = mode0_d & ~mode1_d & PIN_MASK;
	assign res.pad_pull_up      = pull0_d & ~pull1_d & PIN_MASK;
	assign res.pad_pull_down    = pull0_d & pull1_d & PIN_MASK;
	assign res.irq_line         = |(((rise_ip_d & rise_ie_d) | (fall_ip_d & fall_ie_d) |
			(high_ip_d & high_ie_d) | (low_ip_d & low_ie_d)) & PIN_MASK);

endmodule

FILE: sv/gpio_port_with_pin_interrupts.sv
// ----------------------------------------------------------------------------
// GPIO port with pin interrupts
// Register slave for a port of general purpose pins with edge and level
// interrupts; one transaction carries the sampled pins and one bus access.
//
//   channel  direction  tdata fields (lowest bit up)
//   s_axis   in         operation, word_address, write_data, pin_levels
//   m_axis   out        read_data, pad_out_value, pad_drive_enable,
//                       pad_pull_up, pad_pull_down, irq_line
//
// A transaction passes from the input register through the register file
// into the result register. One transaction is taken in every cycle unless
// a stage stalls; the result register and the input register each stall
// only when the stage after them is full.
// Reset clears all pin state words and both valid flags.
// ----------------------------------------------------------------------------
module gpio_port_with_pin_interrupts import gpiopi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// operation, word_address, write_data, pin_levels
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// read_data, pad_out_value, pad_drive_enable, pad_pull_up, pad_pull_down,
	// irq_line, zero padding
	output logic [OUT_W-1:0] m_axis_tdata
);

	in_item_t  item_s1;
	logic      valid_s1;
	res_item_t res_c;
	res_item_t res_s2;
	logic      valid_s2;
	logic      advance;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= in_item_t'(s_axis_tdata);
		end
		if (advance) begin
			res_s2 <= res_c;
		end
	end

	gpiopi_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.res    (res_c)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, res_s2};

endmodule

FILE: tb/tb_gpio_port_with_pin_interrupts.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO port with pin interrupts testbench
// Drives bus accesses and pin levels through the input stream and checks
// every result against a cycle-free prediction of the register file: read
// data, pad controls and the interrupt line. Both stream sides idle at
// random, the receiver holds off for a long stretch once, and the sender
// pauses until all results have been drained.
// ----------------------------------------------------------------------------
module tb_gpio_port_with_pin_interrupts;
	import gpiopi_pkg::*;

	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 150;
	localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

	typedef struct {
		logic [31:0] prev_levels;
		logic [31:0] out_value;
		logic [31:0] mode_lo;
		logic [31:0] mode_hi;
		logic [31:0] pull_lo;
		logic [31:0] pull_hi;
		logic [31:0] rise_en;
		logic [31:0] rise_pend;
		logic [31:0] fall_en;
		logic [31:0] fall_pend;
		logic [31:0] high_en;
		logic [31:0] high_pend;
		logic [31:0] low_en;
		logic [31:0] low_pend;
	} gpio_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	gpio_state_t gpio;
	res_item_t gpio_results_due[$];
	res_item_t got_res;
	res_item_t want_res;
	logic [31:0] last_pins = '0;
	logic steady = 1'b0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_count = 0;
	int error_count = 0;
	int results_checked = 0;
	int reads_sent = 0;
	int writes_sent = 0;
	int idle_sent = 0;

	logic [5:0] mapped_addrs[19] = '{ADR_IVAL, ADR_MODE0, ADR_MODE1, ADR_OVAL,
		ADR_RISE_IE, ADR_RISE_IP, ADR_FALL_IE, ADR_FALL_IP, ADR_HIGH_IE, ADR_HIGH_IP,
		ADR_LOW_IE, ADR_LOW_IP, ADR_OMASK, ADR_SET, ADR_RESET, ADR_TOGGLE,
		ADR_PULL0, ADR_PULL1, ADR_STATUS};

	gpio_port_with_pin_interrupts i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [31:0] enabled_pending(gpio_state_t s);
		return ((s.rise_pend & s.rise_en) | (s.fall_pend & s.fall_en) |
			(s.high_pend & s.high_en) | (s.low_pend & s.low_en)) & PIN_MASK;
	endfunction

	function automatic logic [31:0] register_value(gpio_state_t s, logic [5:0] adr,
			logic [31:0] pins);
		case (adr)
		ADR_IVAL:    return pins;
		ADR_MODE0:   return s.mode_lo;
		ADR_MODE1:   return s.mode_hi;
		ADR_OVAL:    return s.out_value;
		ADR_RISE_IE: return s.rise_en;
		ADR_RISE_IP: return s.rise_pend;
		ADR_FALL_IE: return s.fall_en;
		ADR_FALL_IP: return s.fall_pend;
		ADR_HIGH_IE: return s.high_en;
		ADR_HIGH_IP: return s.high_pend;
		ADR_LOW_IE:  return s.low_en;
		ADR_LOW_IP:  return s.low_pend;
		ADR_PULL0:   return s.pull_lo;
		ADR_PULL1:   return s.pull_hi;
		ADR_STATUS:  return enabled_pending(s);
		default:     return '0;
		endcase
	endfunction

	// Advances the port state by one transaction and returns the pad and read result.
	function automatic res_item_t predict_gpio_result(in_item_t it);
		res_item_t res;
		logic [31:0] pins;
		logic [31:0] data;
		pins = it.pin_levels & PIN_MASK;
		data = it.write_data & PIN_MASK;
		res.read_data = '0;
		if (it.operation == OP_READ) begin
			res.read_data = register_value(gpio, it.word_address, pins) & PIN_MASK;
		end else if (it.operation == OP_WRITE) begin
			case (it.word_address)
			ADR_MODE0:   gpio.mode_lo = data;
			ADR_MODE1:   gpio.mode_hi = data;
			ADR_OVAL:    gpio.out_value = data;
			ADR_RISE_IE: gpio.rise_en = data;
			ADR_RISE_IP: gpio.rise_pend &= data;
			ADR_FALL_IE: gpio.fall_en = data;
			ADR_FALL_IP: gpio.fall_pend &= data;
			ADR_HIGH_IE: gpio.high_en = data;
			ADR_HIGH_IP: gpio.high_pend &= data;
			ADR_LOW_IE:  gpio.low_en = data;
			ADR_LOW_IP:  gpio.low_pend &= data;
			ADR_SET:     gpio.out_value |= data;
			ADR_RESET:   gpio.out_value &= ~data;
			ADR_TOGGLE:  gpio.out_value ^= data;
			ADR_PULL0:   gpio.pull_lo = data;
			ADR_PULL1:   gpio.pull_hi = data;
			default: ;
			endcase
			gpio.out_value &= PIN_MASK;
		end
		gpio.rise_pend |= pins & ~gpio.prev_levels;
		gpio.fall_pend |= ~pins & gpio.prev_levels & PIN_MASK;
		gpio.high_pend |= pins;
		gpio.low_pend |= ~pins & PIN_MASK;
		gpio.prev_levels = pins;
		res.pad_out_value = gpio.out_value;
		res.pad_drive_enable = gpio.mode_lo & ~gpio.mode_hi & PIN_MASK;
		res.pad_pull_up = gpio.pull_lo & ~gpio.pull_hi & PIN_MASK;
		res.pad_pull_down = gpio.pull_lo & gpio.pull_hi & PIN_MASK;
		res.irq_line = (enabled_pending(gpio) != '0);
		return res;
	endfunction

	task automatic send_access(input logic [1:0] op, input logic [5:0] adr,
			input logic [31:0] data, input logic [31:0] pins);
		in_item_t it;
		it.operation = op;
		it.word_address = adr;
		it.write_data = data;
		it.pin_levels = pins;
		while (!steady && $urandom_range(99) < 36) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= IN_W'({$urandom, $urandom, $urandom});
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= it;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		gpio_results_due.push_back(predict_gpio_result(it));
		last_pins = pins;
		if (op == OP_READ)
			reads_sent++;
		else if (op == OP_WRITE)
			writes_sent++;
		else
			idle_sent++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (gpio_results_due.size() != 0);
	endtask

	function automatic logic [31:0] next_pins(logic [31:0] prev);
		case ($urandom_range(9))
		0:       return '0;
		1:       return ALL_ONES;
		2, 3:    return $urandom;
		default: return prev ^ ($urandom & $urandom & $urandom);
		endcase
	endfunction

	function automatic logic [31:0] random_data();
		case ($urandom_range(7))
		0:       return '0;
		1:       return ALL_ONES;
		2:       return $urandom & $urandom;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [5:0] random_address();
		if ($urandom_range(99) < 80)
			return mapped_addrs[$urandom_range(18)];
		return 6'($urandom_range(63));
	endfunction

	function automatic logic [1:0] random_operation();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return OP_WRITE;
		if (r < 80)
			return OP_READ;
		if (r < 90)
			return OP_NONE;
		return OP_SPARE;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_res = res_item_t'(m_axis_tdata[RES_W-1:0]);
			if (gpio_results_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got_res);
				error_count++;
			end else begin
				want_res = gpio_results_due.pop_front();
				check_field("read_data", want_res.read_data, got_res.read_data);
				check_field("pad_out_value", want_res.pad_out_value, got_res.pad_out_value);
				check_field("pad_drive_enable", want_res.pad_drive_enable,
					got_res.pad_drive_enable);
				check_field("pad_pull_up", want_res.pad_pull_up, got_res.pad_pull_up);
				check_field("pad_pull_down", want_res.pad_pull_down, got_res.pad_pull_down);
				check_field("irq_line", 32'(want_res.irq_line), 32'(got_res.irq_line));
			end
			results_checked++;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_ack <= 0;
			hold_count <= 0;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_count <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_count != 0) begin
			hold_count <= hold_count - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= steady || ($urandom_range(99) >= 36);
		end
	end

	task automatic test_interrupt_flags();
		send_access(OP_READ, ADR_IVAL, '0, ALL_ONES);
		send_access(OP_READ, ADR_RISE_IP, ALL_ONES, ALL_ONES);
		send_access(OP_READ, ADR_STATUS, '0, '0);
		send_access(OP_WRITE, ADR_RISE_IE, ALL_ONES, '0);
		send_access(OP_READ, ADR_STATUS, '0, '0);
		send_access(OP_WRITE, ADR_RISE_IP, '0, ALL_ONES);
		send_access(OP_WRITE, ADR_RISE_IP, '0, ALL_ONES);
		send_access(OP_WRITE, ADR_FALL_IE, 32'h0000_ffff, '0);
		send_access(OP_WRITE, ADR_HIGH_IE, 32'hffff_0000, '0);
		send_access(OP_WRITE, ADR_LOW_IE, ALL_ONES, '0);
		send_access(OP_WRITE, ADR_LOW_IP, '0, '0);
		send_access(OP_WRITE, ADR_HIGH_IP, 32'h0f0f_0f0f, '0);
	endtask

	task automatic test_pad_controls();
		send_access(OP_WRITE, ADR_MODE0, ALL_ONES, '0);
		send_access(OP_WRITE, ADR_MODE1, 32'h0000_ffff, ALL_ONES);
		send_access(OP_WRITE, ADR_PULL0, ALL_ONES, ALL_ONES);
		send_access(OP_WRITE, ADR_PULL1, 32'hffff_0000, '0);
		send_access(OP_WRITE, ADR_OVAL, 32'ha5a5_a5a5, '0);
		send_access(OP_WRITE, ADR_SET, 32'h0000_000f, '0);
		send_access(OP_WRITE, ADR_RESET, 32'ha000_0000, '0);
		send_access(OP_WRITE, ADR_TOGGLE, ALL_ONES, '0);
	endtask

	task automatic test_ignored_accesses();
		send_access(OP_WRITE, ADR_OMASK, ALL_ONES, '0);
		send_access(OP_READ, ADR_OMASK, '0, '0);
		send_access(OP_WRITE, ADR_IVAL, ALL_ONES, '0);
		send_access(OP_READ, 6'd63, ALL_ONES, ALL_ONES);
		send_access(OP_SPARE, ADR_OVAL, '0, ALL_ONES);
	endtask

	task automatic test_random_traffic(input int count);
		logic [5:0] pend_adr;
		for (int n = 0; n < count; n++) begin
			steady <= (n >= count / 3) && (n < count / 3 + 300);
			if ($urandom_range(99) < 15) begin
				pend_adr = mapped_addrs[5 + 2 * $urandom_range(3)];
				send_access(OP_READ, ADR_STATUS, random_data(), next_pins(last_pins));
				send_access(OP_READ, pend_adr, random_data(), next_pins(last_pins));
				send_access(OP_WRITE, pend_adr, ~($urandom & $urandom),
					next_pins(last_pins));
				n += 2;
			end else begin
				send_access(random_operation(), random_address(), random_data(),
					next_pins(last_pins));
			end
		end
		steady <= 1'b0;
	endtask

	task automatic test_receiver_hold_off();
		hold_req <= hold_req + 1;
		for (int n = 0; n < 30; n++)
			send_access(random_operation(), random_address(), random_data(),
				next_pins(last_pins));
	endtask

	task automatic test_sender_pause();
		wait_drained();
		for (int n = 0; n < 10; n++)
			send_access(random_operation(), random_address(), random_data(),
				next_pins(last_pins));
	endtask

	initial begin
		gpio = '{default: '0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_interrupt_flags();
		test_pad_controls();
		test_ignored_accesses();
		test_random_traffic(1380);
		test_receiver_hold_off();
		test_sender_pause();
		wait_drained();
		repeat (10) @(posedge clk);
		$display("Checked %0d results from %0d reads, %0d writes and %0d idle accesses.",
			results_checked, reads_sent, writes_sent, idle_sent);
		$display("Pins toggled at random, with a long output hold-off and a drained pause.");
		if (error_count == 0) begin
			$display("tb_gpio_port_with_pin_interrupts OK");
		end else begin
			$display("tb_gpio_port_with_pin_interrupts NOT OK");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("tb_gpio_port_with_pin_interrupts NOT OK");
		$finish;
	end

endmodule
